// ----- sv/pbpm_pkg.sv -----
// Shared types for the packet buffer pool manager core.
// Operation codes and the record carried from the memory access stage to
// the output stage; no dependencies.
package pbpm_pkg;

  localparam int unsigned HandleW = 8;
  localparam int unsigned CountW  = 9;

  typedef enum logic [2:0] {
    OP_REQUEST   = 3'd0,
    OP_RELEASE   = 3'd1,
    OP_AUDIO_ENQ = 3'd2,
    OP_AUDIO_DEQ = 3'd3,
    OP_VIDEO_ENQ = 3'd4,
    OP_VIDEO_DEQ = 3'd5,
    OP_RESET     = 3'd6
  } kind_t;

  typedef enum logic {
    SRC_FREE = 1'b0,
    SRC_AV   = 1'b1
  } src_t;

  // Result being formed while the ring read completes.
  typedef struct packed {
    logic                 ok;
    logic                 take;
    src_t                 src;
    logic                 ident;
    logic [HandleW-1:0]   ident_val;
    logic [CountW-1:0]    free_count;
    logic [CountW-1:0]    audio_count;
    logic [CountW-1:0]    video_count;
  } pend_t;

endpackage

// ----- sv/packet_buffer_pool_manager_core.sv -----
// Packet buffer pool manager: free ring plus audio and video handle queues.
// Holds the free ring and the shared audio/video ring in two synchronous
// memories; depends on pbpm_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one operation item: in_kind
//   selects request, release, audio or video enqueue/dequeue, or pool reset;
//   in_handle_in is the handle for release and enqueue.
//   Result channel (out_valid / out_stall) returns one item per input item:
//   out_ok, out_handle_out and the three ring counts after the operation.
//   The result passes through the access stage, then the output register.
//   Throughput: one item per cycle unless the receiver stalls. Each
//   operation makes at most one access to one memory (free ring or
//   audio/video ring), so one read port per memory never limits the rate.
//   Take on an empty ring, put on a full ring, and the unused code reject
//   with out_ok = 0 and leave the state untouched.
//   Reset (rst_n low) and the reset operation refill the free ring with the
//   identity handles and empty both queues at once: free ring entries not
//   written since then read as their own index, tracked by the tail and a
//   wrap flag, so no clearing pass is needed.
//   When the receiver stalls, the finished result holds in the output
//   register and one more item is taken into the access stage; after that
//   in_stall rises until the output drains.
module packet_buffer_pool_manager_core #(
  parameter int unsigned POOL_SIZE = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [2:0]                  in_kind,
  input  logic [pbpm_pkg::HandleW-1:0] in_handle_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_ok,
  output logic [pbpm_pkg::HandleW-1:0] out_handle_out,
  output logic [pbpm_pkg::CountW-1:0] out_free_count,
  output logic [pbpm_pkg::CountW-1:0] out_audio_count,
  output logic [pbpm_pkg::CountW-1:0] out_video_count
);

  localparam int unsigned PW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int unsigned LW = PW + 1;
  localparam int unsigned HW = pbpm_pkg::HandleW;
  localparam int unsigned CW = pbpm_pkg::CountW;
  localparam logic [LW-1:0] FULL = LW'(POOL_SIZE);
  localparam logic [PW-1:0] LAST = PW'(POOL_SIZE - 1);

  // Ring memories: free ring and audio/video ring (video in the upper half).
  logic [HW-1:0] free_mem [POOL_SIZE];
  logic [HW-1:0] av_mem   [2*POOL_SIZE];
  logic [HW-1:0] free_rd_r;
  logic [HW-1:0] av_rd_r;

  // Ring pointers and levels.
  logic [PW-1:0] free_head_r, free_head_nxt, free_tail_r, free_tail_nxt;
  logic [PW-1:0] aud_head_r, aud_head_nxt, aud_tail_r, aud_tail_nxt;
  logic [PW-1:0] vid_head_r, vid_head_nxt, vid_tail_r, vid_tail_nxt;
  logic [LW-1:0] free_lvl_r, free_lvl_nxt, aud_lvl_r, aud_lvl_nxt;
  logic [LW-1:0] vid_lvl_r, vid_lvl_nxt;
  logic          free_wrap_r, free_wrap_nxt;

  // Access stage and output register.
  logic              pend_valid_r;
  pbpm_pkg::pend_t   pend_r, pend_nxt;
  logic              out_valid_r;
  logic              out_ok_r;
  logic [HW-1:0]     out_handle_r, handle_sel;
  logic [CW-1:0]     out_free_r, out_aud_r, out_vid_r;

  logic              pend_adv, in_acc;
  logic              free_we, free_re, av_we, av_re;
  logic [PW-1:0]     free_addr;
  logic [PW:0]       av_addr;
  logic [LW+CW-1:0]  free_cnt_ext, aud_cnt_ext, vid_cnt_ext;
  logic [PW+HW-1:0]  ident_ext;
  pbpm_pkg::kind_t   kind;

  // Advance the access stage whenever the output register is free or drains.
  assign pend_adv = pend_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = pend_valid_r && !pend_adv;
  assign in_acc   = in_valid && !in_stall;
  assign kind     = pbpm_pkg::kind_t'(in_kind);

  // Decode one operation: pointer/level updates, at most one memory access.
  always_comb begin
    free_head_nxt = free_head_r;
    free_tail_nxt = free_tail_r;
    free_lvl_nxt  = free_lvl_r;
    free_wrap_nxt = free_wrap_r;
    aud_head_nxt  = aud_head_r;
    aud_tail_nxt  = aud_tail_r;
    aud_lvl_nxt   = aud_lvl_r;
    vid_head_nxt  = vid_head_r;
    vid_tail_nxt  = vid_tail_r;
    vid_lvl_nxt   = vid_lvl_r;
    free_we   = 1'b0;
    free_re   = 1'b0;
    av_we     = 1'b0;
    av_re     = 1'b0;
    free_addr = free_head_r;
    av_addr   = {1'b0, aud_head_r};
    pend_nxt  = '0;
    unique case (kind)
      pbpm_pkg::OP_REQUEST: begin
        if (free_lvl_r != '0) begin
          pend_nxt.ok   = 1'b1;
          pend_nxt.take = 1'b1;
          pend_nxt.src  = pbpm_pkg::SRC_FREE;
          // Entries past the tail since the last refill still hold identity.
          pend_nxt.ident = !free_wrap_r && (free_head_r >= free_tail_r);
          free_re       = 1'b1;
          free_addr     = free_head_r;
          free_head_nxt = free_head_r + 1'b1;
          free_lvl_nxt  = free_lvl_r - 1'b1;
        end
      end
      pbpm_pkg::OP_RELEASE: begin
        if (free_lvl_r != FULL) begin
          pend_nxt.ok   = 1'b1;
          free_we       = 1'b1;
          free_addr     = free_tail_r;
          free_tail_nxt = free_tail_r + 1'b1;
          free_lvl_nxt  = free_lvl_r + 1'b1;
          if (free_tail_r == LAST) free_wrap_nxt = 1'b1;
        end
      end
      pbpm_pkg::OP_AUDIO_ENQ: begin
        if (aud_lvl_r != FULL) begin
          pend_nxt.ok  = 1'b1;
          av_we        = 1'b1;
          av_addr      = {1'b0, aud_tail_r};
          aud_tail_nxt = aud_tail_r + 1'b1;
          aud_lvl_nxt  = aud_lvl_r + 1'b1;
        end
      end
      pbpm_pkg::OP_AUDIO_DEQ: begin
        if (aud_lvl_r != '0) begin
          pend_nxt.ok   = 1'b1;
          pend_nxt.take = 1'b1;
          pend_nxt.src  = pbpm_pkg::SRC_AV;
          av_re         = 1'b1;
          av_addr       = {1'b0, aud_head_r};
          aud_head_nxt  = aud_head_r + 1'b1;
          aud_lvl_nxt   = aud_lvl_r - 1'b1;
        end
      end
      pbpm_pkg::OP_VIDEO_ENQ: begin
        if (vid_lvl_r != FULL) begin
          pend_nxt.ok  = 1'b1;
          av_we        = 1'b1;
          av_addr      = {1'b1, vid_tail_r};
          vid_tail_nxt = vid_tail_r + 1'b1;
          vid_lvl_nxt  = vid_lvl_r + 1'b1;
        end
      end
      pbpm_pkg::OP_VIDEO_DEQ: begin
        if (vid_lvl_r != '0) begin
          pend_nxt.ok   = 1'b1;
          pend_nxt.take = 1'b1;
          pend_nxt.src  = pbpm_pkg::SRC_AV;
          av_re         = 1'b1;
          av_addr       = {1'b1, vid_head_r};
          vid_head_nxt  = vid_head_r + 1'b1;
          vid_lvl_nxt   = vid_lvl_r - 1'b1;
        end
      end
      pbpm_pkg::OP_RESET: begin
        pend_nxt.ok   = 1'b1;
        free_head_nxt = '0;
        free_tail_nxt = '0;
        free_lvl_nxt  = FULL;
        free_wrap_nxt = 1'b0;
        aud_head_nxt  = '0;
        aud_tail_nxt  = '0;
        aud_lvl_nxt   = '0;
        vid_head_nxt  = '0;
        vid_tail_nxt  = '0;
        vid_lvl_nxt   = '0;
      end
      default: begin
        // Unused code: reject, leave state alone.
      end
    endcase
    ident_ext          = {{HW{1'b0}}, free_head_r};
    pend_nxt.ident_val = ident_ext[HW-1:0];
    free_cnt_ext       = {{CW{1'b0}}, free_lvl_nxt};
    aud_cnt_ext        = {{CW{1'b0}}, aud_lvl_nxt};
    vid_cnt_ext        = {{CW{1'b0}}, vid_lvl_nxt};
    pend_nxt.free_count  = free_cnt_ext[CW-1:0];
    pend_nxt.audio_count = aud_cnt_ext[CW-1:0];
    pend_nxt.video_count = vid_cnt_ext[CW-1:0];
  end

  // Free ring memory: one write or one registered read per cycle.
  always_ff @(posedge clk) begin
    if (in_acc && free_we) free_mem[free_addr] <= in_handle_in;
    if (in_acc && free_re) free_rd_r <= free_mem[free_addr];
  end

  // Audio/video ring memory.
  always_ff @(posedge clk) begin
    if (in_acc && av_we) av_mem[av_addr] <= in_handle_in;
    if (in_acc && av_re) av_rd_r <= av_mem[av_addr];
  end

  // Pointer and level registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r <= '0;
      free_tail_r <= '0;
      free_lvl_r  <= FULL;
      free_wrap_r <= 1'b0;
      aud_head_r  <= '0;
      aud_tail_r  <= '0;
      aud_lvl_r   <= '0;
      vid_head_r  <= '0;
      vid_tail_r  <= '0;
      vid_lvl_r   <= '0;
    end else if (in_acc) begin
      free_head_r <= free_head_nxt;
      free_tail_r <= free_tail_nxt;
      free_lvl_r  <= free_lvl_nxt;
      free_wrap_r <= free_wrap_nxt;
      aud_head_r  <= aud_head_nxt;
      aud_tail_r  <= aud_tail_nxt;
      aud_lvl_r   <= aud_lvl_nxt;
      vid_head_r  <= vid_head_nxt;
      vid_tail_r  <= vid_tail_nxt;
      vid_lvl_r   <= vid_lvl_nxt;
    end
  end

  // Access stage: hold while the output register is stuck.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else if (in_acc) begin
      pend_valid_r <= 1'b1;
    end else if (pend_adv) begin
      pend_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) pend_r <= pend_nxt;
  end

  // Pick the handle once the ring read has landed.
  always_comb begin
    handle_sel = '0;
    if (pend_r.ok && pend_r.take) begin
      if (pend_r.src == pbpm_pkg::SRC_AV) handle_sel = av_rd_r;
      else if (pend_r.ident)              handle_sel = pend_r.ident_val;
      else                                handle_sel = free_rd_r;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pend_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_adv) begin
      out_ok_r     <= pend_r.ok;
      out_handle_r <= handle_sel;
      out_free_r   <= pend_r.free_count;
      out_aud_r    <= pend_r.audio_count;
      out_vid_r    <= pend_r.video_count;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_handle_out  = out_handle_r;
  assign out_free_count  = out_free_r;
  assign out_audio_count = out_aud_r;
  assign out_video_count = out_vid_r;

  // Checks on the block's own bookkeeping.
  a_stall_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (pend_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked result");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> pend_valid_r)
    else $error("accepted item lost before the output stage");

  a_levels_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (free_lvl_r <= FULL) && (aud_lvl_r <= FULL) && (vid_lvl_r <= FULL))
    else $error("ring level beyond pool size");

  a_reset_op_refills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && kind == pbpm_pkg::OP_RESET) |=>
      (free_lvl_r == FULL && aud_lvl_r == '0 && vid_lvl_r == '0 && !free_wrap_r))
    else $error("reset operation did not refill the pool");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for packet_buffer_pool_manager_core: a tracker of the
// free, audio and video rings predicts every reply item and checks it in order.
// Depends on pbpm_pkg and the core RTL only; reads no files.

localparam int POOL_DEPTH = 1 << pbpm_pkg::HandleW;

typedef enum int {
  RING_FREE  = 0,
  RING_AUDIO = 1,
  RING_VIDEO = 2
} ring_id_t;

typedef struct packed {
  logic                         ok;
  logic [pbpm_pkg::HandleW-1:0] handle;
  logic [pbpm_pkg::CountW-1:0]  free_n;
  logic [pbpm_pkg::CountW-1:0]  audio_n;
  logic [pbpm_pkg::CountW-1:0]  video_n;
} pool_reply_t;

class handle_pool_tracker;
  logic [pbpm_pkg::HandleW-1:0] slot [3][POOL_DEPTH];
  logic [pbpm_pkg::HandleW-1:0] rd_ptr [3];
  logic [pbpm_pkg::HandleW-1:0] wr_ptr [3];
  logic [pbpm_pkg::CountW-1:0]  level [3];
  pool_reply_t                  pending_replies [$];
  int                           mismatch_count;

  function new();
    mismatch_count = 0;
    foreach (slot[r, i]) slot[r][i] = '0;
    refill_pool();
  endfunction

  // Identity handles in the free ring, both queues empty.
  function void refill_pool();
    int i;
    for (i = 0; i < POOL_DEPTH; i++) slot[RING_FREE][i] = pbpm_pkg::HandleW'(i);
    foreach (level[r]) begin
      rd_ptr[r] = '0;
      wr_ptr[r] = '0;
      level[r]  = '0;
    end
    level[RING_FREE] = pbpm_pkg::CountW'(POOL_DEPTH);
  endfunction

  function logic put_handle(ring_id_t r, logic [pbpm_pkg::HandleW-1:0] h);
    if (level[r] == pbpm_pkg::CountW'(POOL_DEPTH)) return 1'b0;
    slot[r][wr_ptr[r]] = h;
    wr_ptr[r] = wr_ptr[r] + 1'b1;
    level[r]  = level[r] + 1'b1;
    return 1'b1;
  endfunction

  function logic take_handle(ring_id_t r, output logic [pbpm_pkg::HandleW-1:0] h);
    h = '0;
    if (level[r] == '0) return 1'b0;
    h = slot[r][rd_ptr[r]];
    rd_ptr[r] = rd_ptr[r] + 1'b1;
    level[r]  = level[r] - 1'b1;
    return 1'b1;
  endfunction

  // Apply one accepted operation and queue the reply it must produce.
  function void apply_op(logic [2:0] kind, logic [pbpm_pkg::HandleW-1:0] h);
    pool_reply_t                  rep;
    logic [pbpm_pkg::HandleW-1:0] taken;
    taken  = '0;
    rep.ok = 1'b0;
    case (pbpm_pkg::kind_t'(kind))
      pbpm_pkg::OP_REQUEST:   rep.ok = take_handle(RING_FREE, taken);
      pbpm_pkg::OP_RELEASE:   rep.ok = put_handle(RING_FREE, h);
      pbpm_pkg::OP_AUDIO_ENQ: rep.ok = put_handle(RING_AUDIO, h);
      pbpm_pkg::OP_AUDIO_DEQ: rep.ok = take_handle(RING_AUDIO, taken);
      pbpm_pkg::OP_VIDEO_ENQ: rep.ok = put_handle(RING_VIDEO, h);
      pbpm_pkg::OP_VIDEO_DEQ: rep.ok = take_handle(RING_VIDEO, taken);
      pbpm_pkg::OP_RESET: begin
        refill_pool();
        rep.ok = 1'b1;
      end
      default:                rep.ok = 1'b0;
    endcase
    rep.handle  = rep.ok ? taken : '0;
    rep.free_n  = level[RING_FREE];
    rep.audio_n = level[RING_AUDIO];
    rep.video_n = level[RING_VIDEO];
    pending_replies.push_back(rep);
  endfunction

  function void compare_field(string name, logic [pbpm_pkg::CountW-1:0] want,
                              logic [pbpm_pkg::CountW-1:0] got);
    if (want !== got) begin
      if (mismatch_count < 40)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  function void check_reply(pool_reply_t got);
    pool_reply_t want;
    if (pending_replies.size() == 0) begin
      if (mismatch_count < 40)
        $display("%0t: reply item with none outstanding, expected none, actual ok=%0b handle=%0d",
                 $time, got.ok, got.handle);
      mismatch_count++;
      return;
    end
    want = pending_replies.pop_front();
    compare_field("ok", pbpm_pkg::CountW'(want.ok), pbpm_pkg::CountW'(got.ok));
    compare_field("handle_out", pbpm_pkg::CountW'(want.handle),
                  pbpm_pkg::CountW'(got.handle));
    compare_field("free_count", want.free_n, got.free_n);
    compare_field("audio_count", want.audio_n, got.audio_n);
    compare_field("video_count", want.video_n, got.video_n);
  endfunction

  function int outstanding();
    return pending_replies.size();
  endfunction
endclass

module testbench;

  // Code 7 is not an operation; the core must reject it untouched.
  localparam logic [2:0] KIND_UNUSED = 3'd7;

  localparam int RANDOM_ITEMS = 1530;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_AFTER   = 400;
  localparam int HOLD_CYCLES  = 320;

  // Traffic shapes for the random bursts. Fill and drain bursts push one
  // ring to its full or empty edge; mixed bursts also reset the pool.
  typedef enum int {
    MIX_ANY     = 0,
    FILL_AUDIO  = 1,
    FILL_VIDEO  = 2,
    DRAIN_FREE  = 3,
    REFILL_FREE = 4,
    DRAIN_AUDIO = 5,
    DRAIN_VIDEO = 6
  } traffic_t;

  logic                         clk          = 1'b0;
  logic                         rst_n        = 1'b0;
  logic                         in_valid     = 1'b0;
  logic                         in_stall;
  logic [2:0]                   in_kind      = '0;
  logic [pbpm_pkg::HandleW-1:0] in_handle_in = '0;
  logic                         out_valid;
  logic                         out_stall    = 1'b0;
  logic                         out_ok;
  logic [pbpm_pkg::HandleW-1:0] out_handle_out;
  logic [pbpm_pkg::CountW-1:0]  out_free_count;
  logic [pbpm_pkg::CountW-1:0]  out_audio_count;
  logic [pbpm_pkg::CountW-1:0]  out_video_count;

  int                 cycle_count = 0;
  handle_pool_tracker pool = new();

  packet_buffer_pool_manager_core u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_handle_in    (in_handle_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_ok          (out_ok),
    .out_handle_out  (out_handle_out),
    .out_free_count  (out_free_count),
    .out_audio_count (out_audio_count),
    .out_video_count (out_video_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watch both channels at the edge. Values read here are the ones from
  // before the edge, so driving with nonblocking assignments cannot race.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      pool.apply_op(in_kind, in_handle_in);
    if (rst_n && out_valid && !out_stall)
      pool.check_reply(pool_reply_t'({out_ok, out_handle_out, out_free_count,
                                      out_audio_count, out_video_count}));
  end

  // Hard stop in case the core hangs or drops a reply.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Sender idle gap: mostly none or short, a few long. Quiet bursts run
  // back to back so the core sees one item per cycle unless it stalls its input.
  function automatic int pick_gap(logic quiet);
    int roll;
    roll = $urandom_range(99);
    if (quiet || roll < 60) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    if (roll < 98) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // Pick an operation for the burst shape. Fill and drain shapes favor one
  // operation heavily so the ring actually hits its edge.
  function automatic logic [2:0] pick_kind(traffic_t mode);
    int         roll;
    logic [2:0] focus;
    roll  = $urandom_range(99);
    focus = pbpm_pkg::OP_REQUEST;
    if (roll == 0) return KIND_UNUSED;
    case (mode)
      FILL_AUDIO:  focus = pbpm_pkg::OP_AUDIO_ENQ;
      FILL_VIDEO:  focus = pbpm_pkg::OP_VIDEO_ENQ;
      DRAIN_FREE:  focus = pbpm_pkg::OP_REQUEST;
      REFILL_FREE: focus = pbpm_pkg::OP_RELEASE;
      DRAIN_AUDIO: focus = pbpm_pkg::OP_AUDIO_DEQ;
      DRAIN_VIDEO: focus = pbpm_pkg::OP_VIDEO_DEQ;
      default: begin
        if (roll < 3) return pbpm_pkg::OP_RESET;
        return 3'($urandom_range(int'(pbpm_pkg::OP_VIDEO_DEQ)));
      end
    endcase
    if (roll < 97) return focus;
    return 3'($urandom_range(int'(pbpm_pkg::OP_VIDEO_DEQ)));
  endfunction

  // Offer one item and hold it until the core takes it. Valid is only
  // lowered when a gap is wanted, so it is never toggled within one step.
  task automatic send_op(logic [2:0] kind, logic [pbpm_pkg::HandleW-1:0] handle,
                         logic quiet);
    int gap;
    gap = pick_gap(quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_handle_in <= handle;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Walk each edge case by hand: empty takes, full put on the free ring,
  // extreme handles, the unused code, and a pool reset with queues loaded.
  task automatic run_directed();
    send_op(pbpm_pkg::OP_AUDIO_DEQ, 8'h00, 1'b0);
    send_op(pbpm_pkg::OP_VIDEO_DEQ, 8'hFF, 1'b0);
    send_op(pbpm_pkg::OP_RELEASE,   8'hFF, 1'b0);
    send_op(pbpm_pkg::OP_REQUEST,   8'h00, 1'b0);
    send_op(pbpm_pkg::OP_REQUEST,   8'hFF, 1'b0);
    send_op(pbpm_pkg::OP_AUDIO_ENQ, 8'hFF, 1'b0);
    send_op(pbpm_pkg::OP_AUDIO_ENQ, 8'h00, 1'b0);
    send_op(pbpm_pkg::OP_VIDEO_ENQ, 8'hA5, 1'b0);
    send_op(pbpm_pkg::OP_VIDEO_ENQ, 8'h5A, 1'b0);
    send_op(KIND_UNUSED,            8'hFF, 1'b0);
    send_op(pbpm_pkg::OP_AUDIO_DEQ, 8'h00, 1'b0);
    send_op(pbpm_pkg::OP_VIDEO_DEQ, 8'h00, 1'b0);
    send_op(pbpm_pkg::OP_RELEASE,   8'h00, 1'b0);
    send_op(pbpm_pkg::OP_RELEASE,   8'h80, 1'b0);
    send_op(pbpm_pkg::OP_RELEASE,   8'h7F, 1'b0);
    send_op(pbpm_pkg::OP_RESET,     8'h33, 1'b0);
    send_op(pbpm_pkg::OP_AUDIO_DEQ, 8'hFF, 1'b0);
    send_op(pbpm_pkg::OP_VIDEO_DEQ, 8'hFF, 1'b0);
    send_op(pbpm_pkg::OP_REQUEST,   8'hFF, 1'b0);
    send_op(KIND_UNUSED,            8'h00, 1'b0);
    send_op(pbpm_pkg::OP_VIDEO_ENQ, 8'h00, 1'b1);
    send_op(pbpm_pkg::OP_VIDEO_DEQ, 8'hFF, 1'b1);
  endtask

  // Random bursts. The first four are long enough to fill the audio and
  // video queues, empty the free ring and then overfill it again; after
  // that, short bursts of random shape mix everything together.
  task automatic run_random();
    int       sent;
    int       len;
    int       burst;
    int       i;
    traffic_t mode;
    logic     quiet;
    sent  = 0;
    burst = 0;
    while (sent < RANDOM_ITEMS) begin
      case (burst)
        0:       mode = FILL_AUDIO;
        1:       mode = FILL_VIDEO;
        2:       mode = DRAIN_FREE;
        3:       mode = REFILL_FREE;
        default: mode = traffic_t'($urandom_range(int'(DRAIN_VIDEO)));
      endcase
      len   = (burst < 4) ? $urandom_range(310, 280) : $urandom_range(120, 20);
      quiet = ($urandom_range(3) == 0);
      for (i = 0; i < len && sent < RANDOM_ITEMS; i++) begin
        send_op(pick_kind(mode), pbpm_pkg::HandleW'($urandom), quiet);
        sent++;
      end
      burst++;
    end
  endtask

  // Receiver: alternate ready stretches and stalls. Once, early in the
  // first fill burst, hold off for a long stretch so the output register
  // and access stage fill and the core has to stall its input.
  initial begin : receiver_stall
    int   run;
    int   hold;
    int   elapsed;
    int   roll;
    logic held;
    elapsed = 0;
    held    = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      roll = $urandom_range(99);
      if (roll < 70) run = $urandom_range(4, 1);
      else if (roll < 90) run = $urandom_range(20, 5);
      else run = $urandom_range(300, 100);
      out_stall <= 1'b0;
      repeat (run) @(posedge clk);
      roll = $urandom_range(99);
      if (!held && elapsed >= HOLD_AFTER) begin
        hold = HOLD_CYCLES;
        held = 1'b1;
      end else if (roll < 75) hold = $urandom_range(2, 1);
      else if (roll < 95) hold = $urandom_range(8, 3);
      else hold = $urandom_range(50, 20);
      out_stall <= 1'b1;
      repeat (hold) @(posedge clk);
      elapsed += run + hold;
    end
  end

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_random();
    in_valid <= 1'b0;
    // Drain every outstanding reply, then linger to catch stray ones.
    while (pool.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pool.mismatch_count == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule
